>>> src/rwf_pkg.sv
// ----------------------------------------------------------------------------
// Replay window filter package
// Shared constants and types for the anti-replay sliding window filter.
// ----------------------------------------------------------------------------
package rwf_pkg;

   // Width of a sequence number.
   localparam int SEQ_W = 16;

   // Number of sequence numbers tracked behind and including the right edge.
   localparam int WINDOW_SIZE = 32;

   // Bits needed to index one position in the window.
   localparam int DIST_W = $clog2(WINDOW_SIZE);

   // Check request handed from the input stage to the window unit.
   typedef struct packed {
      logic             fire;
      logic             func;
      logic [SEQ_W-1:0] sequence_number;
   } win_req_type;

endpackage

>>> src/rwf_window.sv
// ----------------------------------------------------------------------------
// Replay window state and verdict
// Holds the right edge and the seen bitmap, judges one sequence number per
// cycle and records it when asked to.
// ----------------------------------------------------------------------------
module rwf_window (
   input  logic                clock,
   input  logic                reset,
   input  rwf_pkg::win_req_type win_req,
   output logic                accepted
);
   import rwf_pkg::*;

   logic [SEQ_W-1:0]       right_edge_ff;
   logic [SEQ_W-1:0]       right_edge_in;
   logic [WINDOW_SIZE-1:0] seen_bitmap_ff;
   logic [WINDOW_SIZE-1:0] seen_bitmap_in;

   logic              ahead;
   logic [SEQ_W-1:0]  back_dist;
   logic [SEQ_W-1:0]  fwd_dist;
   logic              back_in_window;
   logic              fwd_in_window;
   logic [DIST_W-1:0] back_idx;
   logic [DIST_W-1:0] fwd_shift;
   logic              record;

   // Distances to the right edge in both directions.
   assign ahead          = win_req.sequence_number > right_edge_ff;
   assign back_dist      = right_edge_ff - win_req.sequence_number;
   assign fwd_dist       = win_req.sequence_number - right_edge_ff;
   assign back_in_window = back_dist < SEQ_W'(WINDOW_SIZE);
   assign fwd_in_window  = fwd_dist < SEQ_W'(WINDOW_SIZE);
   assign back_idx       = back_dist[DIST_W-1:0];
   assign fwd_shift      = fwd_dist[DIST_W-1:0];

   // A number beyond the edge is fresh; one inside the window is fresh when
   // its bit is clear; anything older than the window is rejected.
   assign accepted = ahead || (back_in_window && !seen_bitmap_ff[back_idx]);
   assign record   = win_req.fire && win_req.func && accepted;

   // Next state: slide the window forward, or mark a number inside it.
   always_comb begin
      right_edge_in  = right_edge_ff;
      seen_bitmap_in = seen_bitmap_ff;
      if (record) begin
         if (ahead) begin
            seen_bitmap_in = (fwd_in_window ? (seen_bitmap_ff << fwd_shift) : '0)
                             | WINDOW_SIZE'(1);
            right_edge_in  = win_req.sequence_number;
         end else begin
            seen_bitmap_in = seen_bitmap_ff | (WINDOW_SIZE'(1) << back_idx);
         end
      end
   end

   // Window state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         right_edge_ff  <= '0;
         seen_bitmap_ff <= WINDOW_SIZE'(1);
      end else begin
         right_edge_ff  <= right_edge_in;
         seen_bitmap_ff <= seen_bitmap_in;
      end
   end

`ifndef SYNTH
   // The edge itself is always marked as seen.
   a_edge_marked: assert property (@(posedge clock) disable iff (reset)
      seen_bitmap_ff[0])
      else $error("right edge not marked in seen bitmap");

   // A check-only transfer never changes the window.
   a_check_only_stable: assert property (@(posedge clock) disable iff (reset)
      (win_req.fire && !win_req.func) |=>
         ($stable(right_edge_ff) && $stable(seen_bitmap_ff)))
      else $error("check-only transfer altered window state");

   // A recorded number beyond the edge becomes the new edge.
   a_edge_advance: assert property (@(posedge clock) disable iff (reset)
      (record && ahead) |=> (right_edge_ff == $past(win_req.sequence_number)))
      else $error("right edge did not advance to recorded number");

   // The edge never moves backwards.
   a_edge_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (right_edge_ff >= $past(right_edge_ff)) || $past(reset))
      else $error("right edge moved backwards");
`endif

endmodule

>>> src/replay_window_filter_top.sv
// ----------------------------------------------------------------------------
// Replay window filter
// Anti-replay sliding window over 16-bit sequence numbers with a 32-entry
// seen bitmap; one verdict per request.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_func, req_sequence_number
//   rsp      out        rsp_valid, rsp_ready, rsp_accepted
//
// A request is taken into an input register, judged against the window once
// the result register is free and its verdict loaded into the result register;
// one request is taken every cycle while the result is not stalled.
// Reset returns the edge to zero with only bit zero of the bitmap set.
// A stalled result holds both registers; the input register still takes a
// request while it is empty.
// ----------------------------------------------------------------------------
module replay_window_filter_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [rwf_pkg::SEQ_W-1:0] req_sequence_number,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_accepted
);
   import rwf_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic             in_func_ff;
   logic [SEQ_W-1:0] in_seq_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_accepted_ff;
   logic             advance;
   logic             req_xfer;
   logic             verdict;
   win_req_type      win_req;

   // Stage handshakes: the input register moves on when the result register
   // is empty or its transfer completes this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Window unit sees the registered request.
   assign win_req.fire            = advance;
   assign win_req.func            = in_func_ff;
   assign win_req.sequence_number = in_seq_ff;

   rwf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .win_req  (win_req),
      .accepted (verdict)
   );

   // Valid flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_func;
         in_seq_ff  <= req_sequence_number;
      end
      if (advance) begin
         rsp_accepted_ff <= verdict;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

`ifndef SYNTH
   // An accepted request always lands in the input register.
   a_req_captured: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted request not captured");

   // A judged request always produces a pending result.
   a_verdict_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("judged request produced no result");

   // The input register always moves on while the result side is free.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |-> advance)
      else $error("input register stalled with free result register");
`endif

endmodule
